[src/scpa_pkg.sv]
// ----------------------------------------------------------------------------
// scpa_pkg
// Shared types and constants of the size class pool allocator.
// ----------------------------------------------------------------------------
package scpa_pkg;

   localparam int NumClasses    = 15;
   localparam int MaxPooledSize = 640;
   localparam int AddrW         = 19;
   localparam int LinkDepth     = 65536;
   localparam int LinkAddrW     = 16;
   localparam int LinkW         = AddrW + 1;
   localparam int ClassW        = 4;
   localparam int CopyW         = 10;

   localparam logic [9:0] CLASS_BYTES [NumClasses] = '{
      10'd8, 10'd16, 10'd32, 10'd64, 10'd96, 10'd128, 10'd160, 10'd192,
      10'd224, 10'd256, 10'd320, 10'd384, 10'd448, 10'd512, 10'd640
   };

   typedef enum logic [1:0] {
      STAT_DONE = 2'd0,
      STAT_SOFT = 2'd1,
      STAT_OOM  = 2'd2,
      STAT_NONE = 2'd3
   } status_type;

   typedef struct packed {
      logic                 we;
      logic [LinkAddrW-1:0] addr;
      logic [LinkW-1:0]     wdata;
   } link_req_type;

   // class = number of class sizes below the request size
   function automatic logic [ClassW-1:0] class_of(input logic [31:0] size);
      logic [ClassW-1:0] c;
      c = '0;
      for (int i = 0; i < NumClasses - 1; i++) begin
         if (size > 32'(CLASS_BYTES[i])) begin
            c = c + 1'b1;
         end
      end
      return c;
   endfunction

endpackage

[src/scpa_ram.sv]
// ----------------------------------------------------------------------------
// scpa_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module scpa_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

[src/scpa_ctrl.sv]
// ----------------------------------------------------------------------------
// scpa_ctrl
// Request sequencer: class decode, free-list pop/push, chunk carving,
// per-class counters and the result word register.
// ----------------------------------------------------------------------------
module scpa_ctrl
   import scpa_pkg::*;
#(
   parameter int MAX_CHUNKS  = 32,
   parameter int CHUNK_BYTES = 16384,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_old_present,
   input  logic [AddrW-1:0]     req_old_block,
   input  logic [31:0]          req_old_size,
   input  logic [31:0]          req_new_size,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [AddrW-1:0]     rsp_new_block,
   output logic                 rsp_new_block_valid,
   output logic [ClassW-1:0]    rsp_size_class,
   output logic                 rsp_old_released,
   output logic                 rsp_old_to_software,
   output logic [CopyW-1:0]     rsp_copy_length,
   output logic [31:0]          rsp_hit_allocs,
   output logic [31:0]          rsp_hit_frees,
   output logic [5:0]           rsp_chunks_added,
   output link_req_type         link_req,
   input  logic [LinkW-1:0]     link_rdata
);

   localparam int CarveW = $clog2(CHUNK_BYTES / 8 + 1);
   localparam int ChunkW = $clog2(MAX_CHUNKS);
   localparam int UsedW  = $clog2(MAX_CHUNKS + 1);
   localparam int CbW    = $clog2(CHUNK_BYTES + 1);

   localparam logic [CarveW-1:0] PerChunk [NumClasses] = '{
      CarveW'(CHUNK_BYTES / CLASS_BYTES[0]),  CarveW'(CHUNK_BYTES / CLASS_BYTES[1]),
      CarveW'(CHUNK_BYTES / CLASS_BYTES[2]),  CarveW'(CHUNK_BYTES / CLASS_BYTES[3]),
      CarveW'(CHUNK_BYTES / CLASS_BYTES[4]),  CarveW'(CHUNK_BYTES / CLASS_BYTES[5]),
      CarveW'(CHUNK_BYTES / CLASS_BYTES[6]),  CarveW'(CHUNK_BYTES / CLASS_BYTES[7]),
      CarveW'(CHUNK_BYTES / CLASS_BYTES[8]),  CarveW'(CHUNK_BYTES / CLASS_BYTES[9]),
      CarveW'(CHUNK_BYTES / CLASS_BYTES[10]), CarveW'(CHUNK_BYTES / CLASS_BYTES[11]),
      CarveW'(CHUNK_BYTES / CLASS_BYTES[12]), CarveW'(CHUNK_BYTES / CLASS_BYTES[13]),
      CarveW'(CHUNK_BYTES / CLASS_BYTES[14])
   };

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_DECODE  = 6'b000010,
      S_POP     = 6'b000100,
      S_CARVE   = 6'b001000,
      S_RELEASE = 6'b010000,
      S_RESP    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // latched request
   logic              present_ff, present_in;
   logic [AddrW-1:0]  old_block_ff, old_block_in;
   logic [31:0]       old_size_ff, old_size_in;
   logic [31:0]       new_size_ff, new_size_in;

   // per-class state
   logic [AddrW-1:0]       head_ff [NumClasses];
   logic [AddrW-1:0]       head_in [NumClasses];
   logic                   head_valid_ff [NumClasses];
   logic                   head_valid_in [NumClasses];
   logic [ChunkW-1:0]      chunk_ff [NumClasses];
   logic [ChunkW-1:0]      chunk_in [NumClasses];
   logic [CarveW-1:0]      carve_ff [NumClasses];
   logic [CarveW-1:0]      carve_in [NumClasses];
   logic [COUNT_WIDTH-1:0] allocs_ff [NumClasses];
   logic [COUNT_WIDTH-1:0] allocs_in [NumClasses];
   logic [COUNT_WIDTH-1:0] frees_ff [NumClasses];
   logic [COUNT_WIDTH-1:0] frees_in [NumClasses];
   logic [5:0]             added_ff [NumClasses];
   logic [5:0]             added_in [NumClasses];
   logic [UsedW-1:0]       used_ff, used_in;

   // working result
   status_type        status_ff, status_in;
   logic [AddrW-1:0]  nb_ff, nb_in;
   logic              nbv_ff, nbv_in;
   logic [ClassW-1:0] cls_ff, cls_in;
   logic              touched_ff, touched_in;
   logic              rel_ff, rel_in;
   logic              sw_ff, sw_in;
   logic [CopyW-1:0]  copy_ff, copy_in;

   // result word register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [AddrW-1:0]  rsp_nb_ff, rsp_nb_in;
   logic              rsp_nbv_ff, rsp_nbv_in;
   logic [ClassW-1:0] rsp_cls_ff, rsp_cls_in;
   logic              rsp_rel_ff, rsp_rel_in;
   logic              rsp_sw_ff, rsp_sw_in;
   logic [CopyW-1:0]  rsp_copy_ff, rsp_copy_in;
   logic [31:0]       rsp_allocs_ff, rsp_allocs_in;
   logic [31:0]       rsp_frees_ff, rsp_frees_in;
   logic [5:0]        rsp_added_ff, rsp_added_in;

   logic [ClassW-1:0]      new_cls, old_cls;
   logic                   old_pooled;
   logic                   grant;
   logic [AddrW-1:0]       grant_addr;
   logic                   need_chunk;
   logic [ChunkW-1:0]      chunk_sel;
   logic [CarveW-1:0]      carve_sel;
   logic [ChunkW+CbW-1:0]  base_full;
   logic [CarveW+9:0]      offset_full;
   logic [AddrW-1:0]       carve_addr;

   assign new_cls    = class_of(new_size_ff);
   assign old_cls    = class_of(old_size_ff);
   assign old_pooled = present_ff && (old_size_ff <= 32'(MaxPooledSize));

   assign need_chunk  = carve_ff[cls_ff] >= PerChunk[cls_ff];
   assign chunk_sel   = need_chunk ? ChunkW'(used_ff) : chunk_ff[cls_ff];
   assign carve_sel   = need_chunk ? '0 : carve_ff[cls_ff];
   assign base_full   = chunk_sel * CbW'(CHUNK_BYTES);
   assign offset_full = carve_sel * CLASS_BYTES[cls_ff];
   assign carve_addr  = AddrW'(base_full) + AddrW'(offset_full);

   always_comb begin
      state_in     = state_ff;
      present_in   = present_ff;
      old_block_in = old_block_ff;
      old_size_in  = old_size_ff;
      new_size_in  = new_size_ff;
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      chunk_in      = chunk_ff;
      carve_in      = carve_ff;
      allocs_in     = allocs_ff;
      frees_in      = frees_ff;
      added_in      = added_ff;
      used_in       = used_ff;
      status_in  = status_ff;
      nb_in      = nb_ff;
      nbv_in     = nbv_ff;
      cls_in     = cls_ff;
      touched_in = touched_ff;
      rel_in     = rel_ff;
      sw_in      = sw_ff;
      copy_in    = copy_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_nb_in     = rsp_nb_ff;
      rsp_nbv_in    = rsp_nbv_ff;
      rsp_cls_in    = rsp_cls_ff;
      rsp_rel_in    = rsp_rel_ff;
      rsp_sw_in     = rsp_sw_ff;
      rsp_copy_in   = rsp_copy_ff;
      rsp_allocs_in = rsp_allocs_ff;
      rsp_frees_in  = rsp_frees_ff;
      rsp_added_in  = rsp_added_ff;
      link_req.we    = 1'b0;
      link_req.addr  = head_ff[new_cls][AddrW-1:3];
      link_req.wdata = {head_valid_ff[old_cls], head_ff[old_cls]};
      grant      = 1'b0;
      grant_addr = carve_addr;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               present_in   = req_old_present;
               old_block_in = req_old_block;
               old_size_in  = req_old_size;
               new_size_in  = req_new_size;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            nb_in      = '0;
            nbv_in     = 1'b0;
            cls_in     = '0;
            touched_in = 1'b0;
            rel_in     = 1'b0;
            sw_in      = 1'b0;
            copy_in    = '0;
            if (new_size_ff == '0) begin
               if (old_pooled) begin
                  cls_in     = old_cls;
                  touched_in = 1'b1;
                  status_in  = STAT_DONE;
                  state_in   = S_RELEASE;
               end else begin
                  status_in = present_ff ? STAT_SOFT : STAT_NONE;
                  sw_in     = present_ff;
                  state_in  = S_RESP;
               end
            end else if (new_size_ff <= 32'(MaxPooledSize)) begin
               cls_in     = new_cls;
               touched_in = 1'b1;
               state_in   = head_valid_ff[new_cls] ? S_POP : S_CARVE;
            end else begin
               status_in = STAT_SOFT;
               if (old_pooled) begin
                  cls_in     = old_cls;
                  touched_in = 1'b1;
                  copy_in    = CopyW'(old_size_ff);
                  state_in   = S_RELEASE;
               end else begin
                  sw_in    = present_ff;
                  state_in = S_RESP;
               end
            end
         end
         S_POP: begin
            head_in[cls_ff]       = link_rdata[AddrW-1:0];
            head_valid_in[cls_ff] = link_rdata[AddrW];
            grant                 = 1'b1;
            grant_addr            = head_ff[cls_ff];
         end
         S_CARVE: begin
            if (need_chunk && (used_ff >= UsedW'(MAX_CHUNKS))) begin
               status_in = STAT_OOM;
               state_in  = S_RESP;
            end else begin
               if (need_chunk) begin
                  chunk_in[cls_ff] = chunk_sel;
                  used_in          = used_ff + 1'b1;
                  added_in[cls_ff] = added_ff[cls_ff] + 1'b1;
               end
               carve_in[cls_ff] = carve_sel + 1'b1;
               grant            = 1'b1;
            end
         end
         S_RELEASE: begin
            link_req.we           = 1'b1;
            link_req.addr         = old_block_ff[AddrW-1:3];
            head_in[old_cls]       = old_block_ff;
            head_valid_in[old_cls] = 1'b1;
            frees_in[old_cls]      = frees_ff[old_cls] + 1'b1;
            rel_in                 = 1'b1;
            state_in               = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_nb_in     = nb_ff;
               rsp_nbv_in    = nbv_ff;
               rsp_cls_in    = cls_ff;
               rsp_rel_in    = rel_ff;
               rsp_sw_in     = sw_ff;
               rsp_copy_in   = copy_ff;
               rsp_allocs_in = touched_ff ? 32'(allocs_ff[cls_ff]) : '0;
               rsp_frees_in  = touched_ff ? 32'(frees_ff[cls_ff]) : '0;
               rsp_added_in  = touched_ff ? added_ff[cls_ff] : '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (grant) begin
         nb_in             = grant_addr;
         nbv_in            = 1'b1;
         status_in         = STAT_DONE;
         allocs_in[cls_ff] = allocs_ff[cls_ff] + 1'b1;
         state_in          = S_RESP;
         if (present_ff) begin
            copy_in = CopyW'((old_size_ff < new_size_ff) ? old_size_ff : new_size_ff);
            if (old_pooled) begin
               state_in = S_RELEASE;
            end else begin
               sw_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         used_ff      <= UsedW'(NumClasses);
         for (int c = 0; c < NumClasses; c++) begin
            head_ff[c]       <= '0;
            head_valid_ff[c] <= 1'b0;
            chunk_ff[c]      <= ChunkW'(c);
            carve_ff[c]      <= '0;
            allocs_ff[c]     <= '0;
            frees_ff[c]      <= '0;
            added_ff[c]      <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         used_ff       <= used_in;
         head_ff       <= head_in;
         head_valid_ff <= head_valid_in;
         chunk_ff      <= chunk_in;
         carve_ff      <= carve_in;
         allocs_ff     <= allocs_in;
         frees_ff      <= frees_in;
         added_ff      <= added_in;
      end
   end

   always_ff @(posedge clock) begin
      present_ff    <= present_in;
      old_block_ff  <= old_block_in;
      old_size_ff   <= old_size_in;
      new_size_ff   <= new_size_in;
      status_ff     <= status_in;
      nb_ff         <= nb_in;
      nbv_ff        <= nbv_in;
      cls_ff        <= cls_in;
      touched_ff    <= touched_in;
      rel_ff        <= rel_in;
      sw_ff         <= sw_in;
      copy_ff       <= copy_in;
      rsp_status_ff <= rsp_status_in;
      rsp_nb_ff     <= rsp_nb_in;
      rsp_nbv_ff    <= rsp_nbv_in;
      rsp_cls_ff    <= rsp_cls_in;
      rsp_rel_ff    <= rsp_rel_in;
      rsp_sw_ff     <= rsp_sw_in;
      rsp_copy_ff   <= rsp_copy_in;
      rsp_allocs_ff <= rsp_allocs_in;
      rsp_frees_ff  <= rsp_frees_in;
      rsp_added_ff  <= rsp_added_in;
   end

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_new_block       = rsp_nb_ff;
   assign rsp_new_block_valid = rsp_nbv_ff;
   assign rsp_size_class      = rsp_cls_ff;
   assign rsp_old_released    = rsp_rel_ff;
   assign rsp_old_to_software = rsp_sw_ff;
   assign rsp_copy_length     = rsp_copy_ff;
   assign rsp_hit_allocs      = rsp_allocs_ff;
   assign rsp_hit_frees       = rsp_frees_ff;
   assign rsp_chunks_added    = rsp_added_ff;

   a_used_range: assert property (@(posedge clock) disable iff (reset)
      (used_ff <= UsedW'(MAX_CHUNKS)) && (used_ff >= UsedW'(NumClasses)))
      else $error("chunk count out of range");

   a_pop_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |-> ($past(state_ff) == S_DECODE))
      else $error("pop without link read");

   a_grant_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_nbv_ff) |-> (rsp_status_ff == STAT_DONE))
      else $error("granted block with non-done status");

   a_write_release: assert property (@(posedge clock) disable iff (reset)
      link_req.we |-> (state_ff == S_RELEASE) && old_pooled)
      else $error("link write outside release");

endmodule

[src/size_class_pool_allocator_top.sv]
// ----------------------------------------------------------------------------
// size_class_pool_allocator_top
// Size class pool allocator: fifteen LIFO free lists linked in a RAM,
// chunk carving and per-class hit counters.
// ----------------------------------------------------------------------------
// Path from accept: decode, then pop or carve for a pooled size, then release of a
// pooled old block, then the result word; the result register frees the path.
// No new request is taken before the last result word is loaded into its register.
// Reset: synchronous; lists empty, class c owns chunk c, counters zero.
// The link RAM is not cleared; only entries written by a release are used.
module size_class_pool_allocator_top
   import scpa_pkg::*;
#(
   parameter int MAX_CHUNKS  = 32,
   parameter int CHUNK_BYTES = 16384,
   parameter int COUNT_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_old_present,
   input  logic [18:0]       req_old_block,
   input  logic [31:0]       req_old_size,
   input  logic [31:0]       req_new_size,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [18:0]       rsp_new_block,
   output logic              rsp_new_block_valid,
   output logic [3:0]        rsp_size_class,
   output logic              rsp_old_released,
   output logic              rsp_old_to_software,
   output logic [9:0]        rsp_copy_length,
   output logic [31:0]       rsp_hit_allocs,
   output logic [31:0]       rsp_hit_frees,
   output logic [5:0]        rsp_chunks_added
);

   link_req_type     link_req;
   logic [LinkW-1:0] link_rdata;

   scpa_ctrl #(
      .MAX_CHUNKS  (MAX_CHUNKS),
      .CHUNK_BYTES (CHUNK_BYTES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_old_present     (req_old_present),
      .req_old_block       (req_old_block),
      .req_old_size        (req_old_size),
      .req_new_size        (req_new_size),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_new_block       (rsp_new_block),
      .rsp_new_block_valid (rsp_new_block_valid),
      .rsp_size_class      (rsp_size_class),
      .rsp_old_released    (rsp_old_released),
      .rsp_old_to_software (rsp_old_to_software),
      .rsp_copy_length     (rsp_copy_length),
      .rsp_hit_allocs      (rsp_hit_allocs),
      .rsp_hit_frees       (rsp_hit_frees),
      .rsp_chunks_added    (rsp_chunks_added),
      .link_req            (link_req),
      .link_rdata          (link_rdata)
   );

   scpa_ram #(
      .WIDTH (LinkW),
      .DEPTH (LinkDepth)
   ) u_link_ram (
      .clock (clock),
      .we    (link_req.we),
      .addr  (link_req.addr),
      .wdata (link_req.wdata),
      .rdata (link_rdata)
   );

endmodule

[tb/tb_size_class_pool_allocator_top.sv]
// ----------------------------------------------------------------------------
// tb_size_class_pool_allocator_top
// Self-checking bench for the size class pool allocator. Requests are tracked
// against an in-bench allocator model (free lists, chunk carving, counters).
// A directed set of corner requests runs first. Randomized malloc, free,
// realloc, oversized and junk requests follow under four handshake idle
// profiles, with one long response back-pressure window.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_size_class_pool_allocator_top;
   import scpa_pkg::*;

   localparam int MaxChunks  = 32;
   localparam int ChunkBytes = 16384;
   localparam int CycleLimit = 600000;

   typedef struct {
      status_type  status;
      logic [18:0] new_block;
      logic        new_block_valid;
      logic [3:0]  size_class;
      logic        old_released;
      logic        old_to_software;
      logic [9:0]  copy_length;
      logic [31:0] hit_allocs;
      logic [31:0] hit_frees;
      logic [5:0]  chunks_added;
   } alloc_word_type;

   class alloc_scoreboard;
      logic [18:0] head [NumClasses];
      logic        head_ok [NumClasses];
      logic [19:0] links [LinkDepth];
      int unsigned chunk_of [NumClasses];
      int unsigned carve [NumClasses];
      int unsigned chunks_taken;
      logic [31:0] allocs [NumClasses];
      logic [31:0] frees [NumClasses];
      logic [5:0]  added [NumClasses];
      alloc_word_type pending [$];
      alloc_word_type last;
      int errors, checked, oom_seen, soft_seen, release_seen;

      function new();
         for (int c = 0; c < NumClasses; c++) begin
            head[c] = '0;
            head_ok[c] = 1'b0;
            chunk_of[c] = c;
            carve[c] = 0;
            allocs[c] = '0;
            frees[c] = '0;
            added[c] = '0;
         end
         chunks_taken = NumClasses;
         errors = 0;
         checked = 0;
         oom_seen = 0;
         soft_seen = 0;
         release_seen = 0;
      endfunction

      function int size_to_class(logic [31:0] size);
         for (int c = 0; c < NumClasses; c++) begin
            if (size <= 32'(CLASS_BYTES[c])) return c;
         end
         return NumClasses - 1;
      endfunction

      function void push_block(int c, logic [18:0] blk);
         links[blk[18:3]] = {head_ok[c], head[c]};
         head[c] = blk;
         head_ok[c] = 1'b1;
         frees[c] = frees[c] + 1'b1;
      endfunction

      function bit pop_block(int c, output logic [18:0] blk);
         int unsigned per;
         logic [19:0] nxt;
         per = ChunkBytes / int'(CLASS_BYTES[c]);
         if (head_ok[c]) begin
            blk = head[c];
            nxt = links[blk[18:3]];
            head_ok[c] = nxt[19];
            head[c] = nxt[18:0];
            return 1'b1;
         end
         if (carve[c] >= per) begin
            if (chunks_taken >= MaxChunks) return 1'b0;
            chunk_of[c] = chunks_taken;
            chunks_taken++;
            carve[c] = 0;
            added[c] = added[c] + 1'b1;
         end
         blk = 19'(chunk_of[c] * ChunkBytes + carve[c] * int'(CLASS_BYTES[c]));
         carve[c]++;
         return 1'b1;
      endfunction

      function void note_request(logic p, logic [18:0] ob, logic [31:0] os,
                                 logic [31:0] ns);
         alloc_word_type w;
         bit pooled_old, hit;
         int c;
         logic [18:0] blk;
         w = '{STAT_NONE, '0, 1'b0, '0, 1'b0, 1'b0, '0, '0, '0, '0};
         pooled_old = p && os <= MaxPooledSize;
         hit = 1'b0;
         c = 0;
         if (ns == 0) begin
            if (pooled_old) begin
               c = size_to_class(os);
               push_block(c, ob);
               w.status = STAT_DONE;
               w.old_released = 1'b1;
               hit = 1'b1;
            end else if (p) begin
               w.status = STAT_SOFT;
               w.old_to_software = 1'b1;
            end
         end else if (ns <= MaxPooledSize) begin
            c = size_to_class(ns);
            hit = 1'b1;
            if (pop_block(c, blk)) begin
               allocs[c] = allocs[c] + 1'b1;
               w.status = STAT_DONE;
               w.new_block = blk;
               w.new_block_valid = 1'b1;
               if (p) begin
                  w.copy_length = 10'(os < ns ? os : ns);
                  if (pooled_old) begin
                     push_block(size_to_class(os), ob);
                     w.old_released = 1'b1;
                  end else begin
                     w.old_to_software = 1'b1;
                  end
               end
            end else begin
               w.status = STAT_OOM;
            end
         end else begin
            w.status = STAT_SOFT;
            if (pooled_old) begin
               c = size_to_class(os);
               push_block(c, ob);
               w.old_released = 1'b1;
               w.copy_length = 10'(os);
               hit = 1'b1;
            end else begin
               w.old_to_software = p;
            end
         end
         if (hit) begin
            w.size_class = 4'(c);
            w.hit_allocs = allocs[c];
            w.hit_frees = frees[c];
            w.chunks_added = added[c];
         end
         if (w.status == STAT_OOM) oom_seen++;
         if (w.status == STAT_SOFT) soft_seen++;
         if (w.old_released) release_seen++;
         last = w;
         pending.push_back(w);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("MISMATCH word %0d %s: got %0h expected %0h", checked, what, got,
                  want);
         errors++;
      endtask

      task check_result(alloc_word_type g);
         alloc_word_type e;
         if (pending.size() == 0) begin
            report_mismatch("unexpected word", 32'd1, 32'd0);
            return;
         end
         e = pending.pop_front();
         if (g.status != e.status) report_mismatch("status", g.status, e.status);
         if (g.new_block != e.new_block)
            report_mismatch("new_block", g.new_block, e.new_block);
         if (g.new_block_valid != e.new_block_valid)
            report_mismatch("new_block_valid", g.new_block_valid, e.new_block_valid);
         if (g.size_class != e.size_class)
            report_mismatch("size_class", g.size_class, e.size_class);
         if (g.old_released != e.old_released)
            report_mismatch("old_released", g.old_released, e.old_released);
         if (g.old_to_software != e.old_to_software)
            report_mismatch("old_to_software", g.old_to_software, e.old_to_software);
         if (g.copy_length != e.copy_length)
            report_mismatch("copy_length", g.copy_length, e.copy_length);
         if (g.hit_allocs != e.hit_allocs)
            report_mismatch("hit_allocs", g.hit_allocs, e.hit_allocs);
         if (g.hit_frees != e.hit_frees)
            report_mismatch("hit_frees", g.hit_frees, e.hit_frees);
         if (g.chunks_added != e.chunks_added)
            report_mismatch("chunks_added", g.chunks_added, e.chunks_added);
         checked++;
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_old_present;
   logic [18:0] req_old_block;
   logic [31:0] req_old_size;
   logic [31:0] req_new_size;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [18:0] rsp_new_block;
   logic        rsp_new_block_valid;
   logic [3:0]  rsp_size_class;
   logic        rsp_old_released;
   logic        rsp_old_to_software;
   logic [9:0]  rsp_copy_length;
   logic [31:0] rsp_hit_allocs;
   logic [31:0] rsp_hit_frees;
   logic [5:0]  rsp_chunks_added;

   alloc_scoreboard sb;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          cycle_count;
   int          words_received;
   bit          hold_done;
   logic [18:0] live_addr [$];
   logic [31:0] live_size [$];

   size_class_pool_allocator_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_old_present     (req_old_present),
      .req_old_block       (req_old_block),
      .req_old_size        (req_old_size),
      .req_new_size        (req_new_size),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_new_block       (rsp_new_block),
      .rsp_new_block_valid (rsp_new_block_valid),
      .rsp_size_class      (rsp_size_class),
      .rsp_old_released    (rsp_old_released),
      .rsp_old_to_software (rsp_old_to_software),
      .rsp_copy_length     (rsp_copy_length),
      .rsp_hit_allocs      (rsp_hit_allocs),
      .rsp_hit_frees       (rsp_hit_frees),
      .rsp_chunks_added    (rsp_chunks_added)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // response side; one long hold-off once traffic is flowing
   initial begin
      int hold;
      alloc_word_type g;
      hold = 0;
      rsp_ready = 1'b0;
      words_received = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            g.status = status_type'(rsp_status);
            g.new_block = rsp_new_block;
            g.new_block_valid = rsp_new_block_valid;
            g.size_class = rsp_size_class;
            g.old_released = rsp_old_released;
            g.old_to_software = rsp_old_to_software;
            g.copy_length = rsp_copy_length;
            g.hit_allocs = rsp_hit_allocs;
            g.hit_frees = rsp_hit_frees;
            g.chunks_added = rsp_chunks_added;
            sb.check_result(g);
            words_received++;
         end
         if (!hold_done && words_received == 60) begin
            hold_done = 1'b1;
            hold = 300;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !reset && ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   task send_word(logic p, logic [18:0] ob, logic [31:0] os, logic [31:0] ns);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_old_present <= p;
      req_old_block <= ob;
      req_old_size <= os;
      req_new_size <= ns;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(p, ob, os, ns);
   endtask

   // send and keep the live block list in step with the predicted grant
   task request(logic p, logic [18:0] ob, logic [31:0] os, logic [31:0] ns);
      send_word(p, ob, os, ns);
      if (sb.last.new_block_valid) begin
         live_addr.push_back(sb.last.new_block);
         live_size.push_back(ns);
      end
   endtask

   task random_request();
      int k, i;
      logic [18:0] a;
      logic [31:0] s, ns;
      k = $urandom_range(0, 99);
      ns = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 640) : $urandom_range(449, 640);
      if (k < 45 || (k < 78 && live_addr.size() == 0)) begin
         request(1'b0, 19'($urandom), $urandom, ns);
      end else if (k < 78) begin
         i = $urandom_range(0, live_addr.size() - 1);
         a = live_addr[i];
         s = live_size[i];
         if (k < 65) begin
            live_addr.delete(i);
            live_size.delete(i);
            request(1'b1, a, s, 32'd0);
         end else begin
            ns = $urandom_range(1, 720);
            send_word(1'b1, a, s, ns);
            if (sb.last.status != STAT_OOM) begin
               live_addr.delete(i);
               live_size.delete(i);
            end
            if (sb.last.new_block_valid) begin
               live_addr.push_back(sb.last.new_block);
               live_size.push_back(ns);
            end
         end
      end else if (k < 84) begin
         request(1'($urandom_range(0, 1)), 19'($urandom), $urandom_range(641, 100000),
                 $urandom_range(641, 32'hFFFF_FFFF));
      end else if (k < 88) begin
         request(1'b1, 19'($urandom), $urandom_range(641, 32'hFFFF_FFFF), 32'd0);
      end else if (k < 92) begin
         request(1'b0, 19'($urandom), $urandom, 32'd0);
      end else begin
         request(1'($urandom_range(0, 1)), 19'($urandom),
                 ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 700),
                 ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 700));
      end
   endtask

   initial begin
      int settle;
      sb = new();
      cycle_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_old_present <= 1'b0;
      req_old_block <= '0;
      req_old_size <= '0;
      req_new_size <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner requests
      request(1'b0, 19'h7FFFF, 32'hFFFF_FFFF, 32'd0);
      request(1'b0, '0, '0, 32'd1);
      request(1'b0, '0, '0, 32'd8);
      request(1'b0, '0, '0, 32'd9);
      request(1'b0, '0, '0, 32'd640);
      request(1'b0, '0, '0, 32'd641);
      request(1'b0, '0, '0, 32'hFFFF_FFFF);
      request(1'b1, live_addr[0], 32'd1, 32'd0);
      request(1'b0, '0, '0, 32'd5);
      request(1'b1, live_addr[3], 32'd640, 32'd100);
      request(1'b1, live_addr[1], 32'd8, 32'd640);
      request(1'b1, 19'h12345, 32'd641, 32'd64);
      request(1'b1, 19'h54321, 32'hFFFF_FFFF, 32'd8);
      request(1'b1, 19'h7FFFF, 32'd0, 32'd0);
      request(1'b1, 19'h7FFFF, 32'd0, 32'd3);
      request(1'b1, 19'h00100, 32'd640, 32'hFFFF_FFFF);
      request(1'b1, 19'h00200, 32'd641, 32'd641);
      request(1'b1, 19'h00300, 32'h8000_0000, 32'd0);
      request(1'b0, '0, '0, 32'd640);
      request(1'b0, '0, '0, 32'd640);
      live_addr.delete();
      live_size.delete();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 62 : 33) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 62 : 33) : 0;
         for (int n = 0; n < 408; n++) random_request();
      end
      req_valid <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;

      while (sb.pending.size() != 0) @(posedge clock);
      settle = 0;
      while (settle < 20) begin
         @(posedge clock);
         settle++;
      end
      $display("Checked %0d response words: %0d out of memory, %0d to software,",
               sb.checked, sb.oom_seen, sb.soft_seen);
      $display("%0d old blocks released, %0d of %0d chunks in use.", sb.release_seen,
               sb.chunks_taken, MaxChunks);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
